// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never occurs, disabled while reset is held.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/rps_pkg.sv =====
`timescale 1ns / 1ps

package rps_pkg;

    localparam int IDX_W   = 4;
    localparam int STEP_W  = 5;
    localparam int VALUE_W = 16;
    localparam int TEMP_W  = 10;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_LOWER = 2'd0,
        KIND_UPPER = 2'd1,
        KIND_WAIT  = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } point_t;

    typedef struct packed {
        cmd_t                command;
        logic [IDX_W-1:0]    point_index;
        kind_t               point_kind;
        logic [VALUE_W-1:0]  point_value;
        logic [TEMP_W-1:0]   lower_temp;
        logic [TEMP_W-1:0]   upper_temp;
    } item_t;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_W-1:0]    wr_addr;
        point_t              wr_point;
        logic [IDX_W-1:0]    rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  lower_setpoint;
        logic [VALUE_W-1:0]  upper_setpoint;
        logic                running;
        logic [STEP_W-1:0]   step_index;
        logic                finished;
    } result_t;

endpackage

// ===== hdl/rps_point_mem.sv =====
`timescale 1ns / 1ps

module rps_point_mem #(
    parameter int DEPTH = 16
) (
    input  logic              aclk,
    input  rps_pkg::mem_req_t mem_req,
    output rps_pkg::point_t   rd_point
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rps_pkg::point_t mem [DEPTH];
    rps_pkg::point_t rd_point_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_point;
        end
        rd_point_reg <= mem[mem_req.rd_addr[AW-1:0]];
    end

    assign rd_point = rd_point_reg;

endmodule

// ===== hdl/rps_ctrl.sv =====
`timescale 1ns / 1ps

module rps_ctrl #(
    parameter int MAX_POINTS = 16,
    parameter int DEPTH      = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rps_pkg::STEP_W-1:0]  cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  rps_pkg::item_t              s_item,
    input  rps_pkg::point_t             rd_point,
    output rps_pkg::mem_req_t           mem_req,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output rps_pkg::result_t            m_result
);

    localparam int CAP = (MAX_POINTS > 31) ? 31 : MAX_POINTS;
    localparam logic [rps_pkg::STEP_W-1:0] CAP_V   = rps_pkg::STEP_W'(CAP);
    localparam logic [rps_pkg::STEP_W-1:0] DEPTH_V = rps_pkg::STEP_W'(DEPTH);

    rps_pkg::state_t                state_reg, state_next;
    rps_pkg::item_t                 item_reg;
    logic [rps_pkg::STEP_W-1:0]     step_reg, step_next;
    logic                           run_reg, run_next;
    logic [rps_pkg::VALUE_W-1:0]    tick_reg, tick_next;
    logic [rps_pkg::VALUE_W-1:0]    lower_reg, lower_next;
    logic [rps_pkg::VALUE_W-1:0]    upper_reg, upper_next;
    logic [rps_pkg::STEP_W-1:0]     count_reg;
    logic                           out_valid_reg, out_valid_next;
    rps_pkg::result_t               result_reg, result_next;

    logic [rps_pkg::STEP_W-1:0]     limit;
    logic [rps_pkg::VALUE_W-1:0]    tick_inc;
    logic                           fin;
    logic                           accept;

    assign accept   = s_tvalid && (state_reg == rps_pkg::ST_IDLE);
    assign s_tready = (state_reg == rps_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_result = result_reg;
    assign limit    = (count_reg > CAP_V) ? CAP_V : count_reg;
    assign tick_inc = (tick_reg < rd_point.value) ? tick_reg + 16'd1 : tick_reg;

    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        run_next         = run_reg;
        tick_next        = tick_reg;
        lower_next       = lower_reg;
        upper_next       = upper_reg;
        fin              = 1'b0;
        out_valid_next   = out_valid_reg && !m_tready;
        result_next      = result_reg;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = item_reg.point_index;
        mem_req.wr_point = '{kind: item_reg.point_kind, value: item_reg.point_value};
        mem_req.rd_addr  = step_reg[rps_pkg::IDX_W-1:0];

        unique case (state_reg)
            rps_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rps_pkg::ST_EXEC;
                end
            end
            rps_pkg::ST_EXEC: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = rps_pkg::ST_IDLE;
                    unique case (item_reg.command)
                        rps_pkg::CMD_LOAD: begin
                            if (!run_reg && ({1'b0, item_reg.point_index} < DEPTH_V)) begin
                                mem_req.wr_en = 1'b1;
                            end
                        end
                        rps_pkg::CMD_START: begin
                            step_next = '0;
                            tick_next = '0;
                            run_next  = 1'b1;
                        end
                        rps_pkg::CMD_STOP: begin
                            fin        = run_reg;
                            run_next   = 1'b0;
                            lower_next = '0;
                            upper_next = '0;
                            tick_next  = '0;
                        end
                        rps_pkg::CMD_TICK: begin
                            priority if (!run_reg) begin
                                lower_next = '0;
                                upper_next = '0;
                            end else if (step_reg >= limit) begin
                                fin        = 1'b1;
                                run_next   = 1'b0;
                                lower_next = '0;
                                upper_next = '0;
                                tick_next  = '0;
                            end else begin
                                unique case (rd_point.kind)
                                    rps_pkg::KIND_LOWER: begin
                                        lower_next = rd_point.value;
                                        if (rps_pkg::VALUE_W'(item_reg.lower_temp)
                                                >= rd_point.value) begin
                                            step_next = step_reg + 5'd1;
                                            tick_next = '0;
                                        end
                                    end
                                    rps_pkg::KIND_UPPER: begin
                                        upper_next = rd_point.value;
                                        if (rps_pkg::VALUE_W'(item_reg.upper_temp)
                                                >= rd_point.value) begin
                                            step_next = step_reg + 5'd1;
                                            tick_next = '0;
                                        end
                                    end
                                    rps_pkg::KIND_WAIT: begin
                                        tick_next = tick_inc;
                                        if (tick_inc >= rd_point.value) begin
                                            step_next = step_reg + 5'd1;
                                            tick_next = '0;
                                        end
                                    end
                                    rps_pkg::KIND_END: begin
                                        fin        = 1'b1;
                                        run_next   = 1'b0;
                                        lower_next = '0;
                                        upper_next = '0;
                                        tick_next  = '0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                    out_valid_next             = 1'b1;
                    result_next.lower_setpoint = lower_next;
                    result_next.upper_setpoint = upper_next;
                    result_next.running        = run_next;
                    result_next.step_index     = step_next;
                    result_next.finished       = fin;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rps_pkg::ST_IDLE;
            step_reg      <= '0;
            run_reg       <= 1'b0;
            tick_reg      <= '0;
            lower_reg     <= '0;
            upper_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            run_reg       <= run_next;
            tick_reg      <= tick_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        if (accept) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/reflow_profile_sequencer.sv =====
`timescale 1ns / 1ps

// Reflow profile sequencer: loads up to MAX_POINTS profile points (at most 16 addressable
// slots) into a point memory with load transactions while idle, then on each tick
// transaction of a run evaluates the current point (lower heat, upper heat, wait, end) and
// returns one result transaction per input transaction with both setpoints, the run flag,
// the step index, and tlast marking the transaction on which a run ends. Each transaction
// passes through the idle state, where the point memory at the current step is read into
// its output register, and the execute state, which executes the step and writes back.
// A new input is taken while an earlier result still waits on m_tready; the execute
// state stalls until the result register frees.
module reflow_profile_sequencer #(
    parameter int MAX_POINTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,     // point_count
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] point_index, [5:4] point_kind, [21:6] point_value,
    // [31:22] lower_temp, [41:32] upper_temp, [47:42] zero
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,         // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] lower_setpoint, [31:16] upper_setpoint, [32] running,
    // [37:33] step_index, [39:38] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast          // finished
);

    localparam int DEPTH = (MAX_POINTS < 16) ? MAX_POINTS : 16;

    rps_pkg::item_t    s_item;
    rps_pkg::point_t   rd_point;
    rps_pkg::mem_req_t mem_req;
    rps_pkg::result_t  m_result;

    assign s_item.command     = rps_pkg::cmd_t'(s_tuser);
    assign s_item.point_index = s_tdata[3:0];
    assign s_item.point_kind  = rps_pkg::kind_t'(s_tdata[5:4]);
    assign s_item.point_value = s_tdata[21:6];
    assign s_item.lower_temp  = s_tdata[31:22];
    assign s_item.upper_temp  = s_tdata[41:32];

    assign m_tdata = {2'b00, m_result.step_index, m_result.running,
                      m_result.upper_setpoint, m_result.lower_setpoint};
    assign m_tlast = m_result.finished;

    rps_point_mem #(
        .DEPTH (DEPTH)
    ) u_point_mem (
        .aclk     (aclk),
        .mem_req  (mem_req),
        .rd_point (rd_point)
    );

    rps_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .DEPTH      (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_item      (s_item),
        .rd_point    (rd_point),
        .mem_req     (mem_req),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (m_result)
    );

`include "assert_macros.svh"

    `ASSERT_NEVER(a_fin_not_running, aclk, aresetn, m_tvalid && m_tlast && m_tdata[32], "run end reported while still running")
    `ASSERT_CLK(a_idle_zero_setpoints, aclk, aresetn, (m_tvalid && !m_tdata[32]) |-> (m_tdata[31:0] == 32'd0), "setpoints not zero while idle")
    `ASSERT_CLK(a_exec_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "input taken again before the step executed")

endmodule
